[sv/ale_pkg.sv]
// Shared types and codes for the array list engine.
`default_nettype none

package ale_pkg;

    localparam int KIND_W     = 4;
    localparam int POS_W      = 5;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int IDX_W      = 4;
    localparam int LEN_W      = 5;
    // widest table address over the supported capacity range (up to 1024)
    localparam int ADDR_W_MAX = 10;

    localparam logic [KIND_W-1:0] KIND_INS_HEAD = 4'd0;
    localparam logic [KIND_W-1:0] KIND_INS_TAIL = 4'd1;
    localparam logic [KIND_W-1:0] KIND_INS_POS  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_POS  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_READ     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_REPLACE  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_FIND     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_DEDUPE   = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef logic [ADDR_W_MAX-1:0] addr_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [WORD_W-1:0]     word_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        word_t               data;
        idx_t                found_index;
        len_t                length;
    } res_t;

endpackage

`default_nettype wire

[sv/array_list_engine_top.sv]
// Array list engine top level: sequencer, entry table and result register.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_*     | in  | position[4:0] value[36:5] new_value[68:37] pad[71:69] | kind[3:0]
//  m_*     | out | data[31:0] found_index[35:32] length[40:36] pad[47:41]| status[2:0]
//
// One item at a time. The table has one read and one write port, and its read
// data is registered, so each shifted or scanned entry takes a read step and
// then a write or check step.
// A result waits in the output register while the next item is accepted.
// Reset empties the list at once; table contents are not cleared.
`default_nettype none

module array_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // position, value, new_value, zero pad
    input  wire logic [3:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // data, found_index, length, zero pad
    output logic [2:0]       m_tuser    // status
);

    ale_pkg::mem_req_t mem_req;
    logic [31:0]       mem_rd_data;
    ale_pkg::res_t     res;
    logic              res_valid;
    logic              res_ready;

    logic              m_tvalid_reg;
    ale_pkg::res_t     out_reg;

    ale_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (s_tuser),
        .position    (s_tdata[4:0]),
        .value       (s_tdata[36:5]),
        .new_value   (s_tdata[68:37]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    ale_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.length, out_reg.found_index, out_reg.data};

endmodule

`default_nettype wire

[sv/ale_mem.sv]
// Entry table: one write port, one read port, registered read data.
`default_nettype none

module ale_mem #(
    parameter int CAPACITY = 16
) (
    input  wire logic              clk,
    input  wire ale_pkg::mem_req_t req,
    output logic [31:0]            rd_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [31:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

[sv/ale_seq.sv]
// Operation sequencer: walks the entry table with read/modify/write steps.
`default_nettype none

module ale_seq #(
    parameter int CAPACITY = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [3:0]            kind,
    input  wire logic [4:0]            position,
    input  wire logic [31:0]           value,
    input  wire logic [31:0]           new_value,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output ale_pkg::res_t              res,
    output ale_pkg::mem_req_t          mem_req,
    input  wire logic [31:0]           mem_rd_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPEN_RD,
        S_OPEN_WR,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DD_I,
        S_DD_IW,
        S_DD_J,
        S_DD_JC,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       at_reg, at_next;
    logic [CW-1:0]       kept_reg, kept_next;
    logic [31:0]         val_reg, val_next;
    logic [31:0]         nval_reg, nval_next;
    logic [31:0]         cand_reg, cand_next;
    logic                find_reg, find_next;
    logic                hit_reg, hit_next;
    logic [2:0]          status_reg, status_next;
    logic [31:0]         data_reg, data_next;
    ale_pkg::idx_t       idx_reg, idx_next;

    logic                full, empty, pos_ok;
    logic [XW-1:0]       pos_x, cnt_x;
    logic [CW-1:0]       pos_m1, i_p1;

    assign pos_x  = XW'(position);
    assign cnt_x  = XW'(count_reg);
    assign pos_m1 = CW'(pos_x - 1'b1);
    assign i_p1   = i_reg + 1'b1;
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign pos_ok = (position != '0) && (pos_x <= cnt_x);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{status:      status_reg,
                         data:        data_reg,
                         found_index: idx_reg,
                         length:      ale_pkg::len_t'(count_reg)};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        at_next     = at_reg;
        kept_next   = kept_reg;
        val_next    = val_reg;
        nval_next   = nval_reg;
        cand_next   = cand_reg;
        find_next   = find_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        data_next   = data_reg;
        idx_next    = idx_reg;
        mem_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next    = value;
                    nval_next   = new_value;
                    status_next = ale_pkg::ST_OK;
                    data_next   = '0;
                    idx_next    = '0;
                    i_next      = count_reg;
                    state_next  = S_DONE;
                    case (kind)
                        ale_pkg::KIND_INS_HEAD:
                        begin
                            if (full)
                                status_next = ale_pkg::ST_FULL;
                            else
                            begin
                                at_next    = '0;
                                state_next = S_OPEN_RD;
                            end
                        end
                        ale_pkg::KIND_INS_TAIL:
                        begin
                            if (full)
                                status_next = ale_pkg::ST_FULL;
                            else
                            begin
                                at_next    = count_reg;
                                state_next = S_OPEN_RD;
                            end
                        end
                        ale_pkg::KIND_INS_POS:
                        begin
                            if (full)
                                status_next = ale_pkg::ST_FULL;
                            else if (!pos_ok)
                                status_next = ale_pkg::ST_BADPOS;
                            else
                            begin
                                at_next    = pos_m1;
                                state_next = S_OPEN_RD;
                            end
                        end
                        ale_pkg::KIND_DEL_HEAD:
                        begin
                            if (empty)
                                status_next = ale_pkg::ST_EMPTY;
                            else
                            begin
                                i_next     = '0;
                                state_next = S_CLOSE_RD;
                            end
                        end
                        ale_pkg::KIND_DEL_TAIL:
                        begin
                            if (empty)
                                status_next = ale_pkg::ST_EMPTY;
                            else
                            begin
                                i_next     = count_reg - 1'b1;
                                state_next = S_CLOSE_RD;
                            end
                        end
                        ale_pkg::KIND_DEL_POS:
                        begin
                            if (empty)
                                status_next = ale_pkg::ST_EMPTY;
                            else if (!pos_ok)
                                status_next = ale_pkg::ST_BADPOS;
                            else
                            begin
                                i_next     = pos_m1;
                                state_next = S_CLOSE_RD;
                            end
                        end
                        ale_pkg::KIND_READ:
                        begin
                            if (!pos_ok)
                                status_next = ale_pkg::ST_BADPOS;
                            else
                            begin
                                i_next     = pos_m1;
                                state_next = S_READ_RD;
                            end
                        end
                        ale_pkg::KIND_REPLACE, ale_pkg::KIND_FIND:
                        begin
                            if (empty)
                                status_next = ale_pkg::ST_EMPTY;
                            else
                            begin
                                i_next     = '0;
                                hit_next   = 1'b0;
                                find_next  = (kind == ale_pkg::KIND_FIND);
                                state_next = S_SCAN_RD;
                            end
                        end
                        ale_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ale_pkg::KIND_DEDUPE:
                        begin
                            i_next     = '0;
                            kept_next  = '0;
                            state_next = S_DD_I;
                        end
                        default:
                        begin
                            status_next = ale_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // open a gap at at_reg, moving entries up from the tail
            S_OPEN_RD:
            begin
                if (i_reg > at_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ale_pkg::addr_t'(i_reg - 1'b1);
                    state_next    = S_OPEN_WR;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ale_pkg::addr_t'(at_reg);
                    mem_req.wdata = val_reg;
                    count_next    = count_reg + 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_OPEN_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ale_pkg::addr_t'(i_reg);
                mem_req.wdata = mem_rd_data;
                i_next        = i_reg - 1'b1;
                state_next    = S_OPEN_RD;
            end

            // close the gap at i_reg, moving entries down toward it
            S_CLOSE_RD:
            begin
                if (i_p1 < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ale_pkg::addr_t'(i_p1);
                    state_next    = S_CLOSE_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_CLOSE_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ale_pkg::addr_t'(i_reg);
                mem_req.wdata = mem_rd_data;
                i_next        = i_p1;
                state_next    = S_CLOSE_RD;
            end

            S_READ_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ale_pkg::addr_t'(i_reg);
                state_next    = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                data_next  = mem_rd_data;
                state_next = S_DONE;
            end

            // shared walk for find and replace-all
            S_SCAN_RD:
            begin
                if (i_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ale_pkg::addr_t'(i_reg);
                    state_next    = S_SCAN_CHK;
                end
                else
                begin
                    status_next = hit_reg ? ale_pkg::ST_OK : ale_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end
            S_SCAN_CHK:
            begin
                i_next     = i_p1;
                state_next = S_SCAN_RD;
                if (mem_rd_data == val_reg)
                begin
                    if (find_reg)
                    begin
                        idx_next    = ale_pkg::idx_t'(i_reg);
                        status_next = ale_pkg::ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = ale_pkg::addr_t'(i_reg);
                        mem_req.wdata = nval_reg;
                        hit_next      = 1'b1;
                    end
                end
            end

            // dedupe: entry i survives only if no later entry matches it;
            // survivors compact to kept_reg, which never passes i_reg
            S_DD_I:
            begin
                if (i_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ale_pkg::addr_t'(i_reg);
                    state_next    = S_DD_IW;
                end
                else
                begin
                    count_next = kept_reg;
                    state_next = S_DONE;
                end
            end
            S_DD_IW:
            begin
                cand_next  = mem_rd_data;
                j_next     = i_p1;
                state_next = S_DD_J;
            end
            S_DD_J:
            begin
                if (j_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ale_pkg::addr_t'(j_reg);
                    state_next    = S_DD_JC;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ale_pkg::addr_t'(kept_reg);
                    mem_req.wdata = cand_reg;
                    kept_next     = kept_reg + 1'b1;
                    i_next        = i_p1;
                    state_next    = S_DD_I;
                end
            end
            S_DD_JC:
            begin
                if (mem_rd_data == cand_reg)
                begin
                    i_next     = i_p1;
                    state_next = S_DD_I;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_DD_J;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        at_reg     <= at_next;
        kept_reg   <= kept_next;
        val_reg    <= val_next;
        nval_reg   <= nval_next;
        cand_reg   <= cand_next;
        find_reg   <= find_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        idx_reg    <= idx_next;
    end

endmodule

`default_nettype wire

[sv/ale_chk.sv]
// Port-level checker for the array list engine, bound to the top level.
`default_nettype none

module ale_chk #(
    parameter int CAPACITY = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // data and index are zero unless the operation succeeded
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ale_pkg::ST_OK) |-> (m_tdata[35:0] == '0))
        else $error("data or index set on a failed operation");

    // a full rejection reports a list at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ale_pkg::ST_FULL)
        |-> (m_tdata[40:36] == ale_pkg::len_t'(CAPACITY)))
        else $error("full status with list below capacity");

    // an empty rejection reports length zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ale_pkg::ST_EMPTY) |-> (m_tdata[40:36] == '0))
        else $error("empty status with nonzero length");

endmodule

bind array_list_engine_top ale_chk #(.CAPACITY(CAPACITY)) u_ale_chk (.*);

`default_nettype wire
